@@ src/b64se_pkg.sv @@
package b64se_pkg;

    // Depth of the group queue between the front and the back parts.
    localparam int QueueDepth = 2;

    // ASCII code of the padding character.
    localparam logic [7:0] PadChar = 8'h3D;

    // Number of padding characters that close a group.
    localparam logic [1:0] PadNone = 2'd0;
    localparam logic [1:0] PadOne  = 2'd1;
    localparam logic [1:0] PadTwo  = 2'd2;

    // Position of the last character within a group of four.
    localparam logic [1:0] LastSlot = 2'd3;

    // One queued group: up to three bytes, the padding count and the message end flag.
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  pad;
        logic        last;
    } group_t;

    // Maps a six-bit value onto the standard alphabet.
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] code;
        begin
            code = 8'h2F;
            if (v < 6'd26) begin
                code = 8'(v) + 8'h41;
            end
            else if (v < 6'd52) begin
                code = 8'(v) + 8'h47;
            end
            else if (v < 6'd62) begin
                code = 8'(v) - 8'h04;
            end
            else if (v == 6'd62) begin
                code = 8'h2B;
            end
            return code;
        end
    endfunction

endpackage

@@ src/b64se_front.sv @@
module b64se_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic                  q_full,
    output logic                  full,
    output logic                  q_wr,
    output b64se_pkg::group_t     q_data
);

    logic [15:0] pend_reg;
    logic [15:0] pend_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        accept;

    // Bytes are taken whenever the queue can hold one more group.
    assign full   = q_full;
    assign accept = push && !q_full;

    // Classify the byte: store it, or close a group and hand it to the queue.
    always_comb
    begin
        pend_next      = pend_reg;
        count_next     = count_reg;
        q_wr           = 1'b0;
        q_data.bytes   = {pend_reg, data_byte};
        q_data.pad     = b64se_pkg::PadNone;
        q_data.last    = last_byte;
        if (count_reg[1]) begin
            q_data.bytes = {pend_reg, data_byte};
            q_data.pad   = b64se_pkg::PadNone;
        end
        else if (count_reg == 2'd0) begin
            q_data.bytes = {data_byte, 16'h0000};
            q_data.pad   = b64se_pkg::PadTwo;
        end
        else begin
            q_data.bytes = {pend_reg[15:8], data_byte, 8'h00};
            q_data.pad   = b64se_pkg::PadOne;
        end
        if (accept) begin
            if (count_reg[1] || last_byte) begin
                q_wr       = 1'b1;
                pend_next  = 16'h0000;
                count_next = 2'd0;
            end
            else if (count_reg == 2'd0) begin
                pend_next  = {data_byte, 8'h00};
                count_next = 2'd1;
            end
            else begin
                pend_next  = {pend_reg[15:8], data_byte};
                count_next = 2'd2;
            end
        end
    end

    // Pending bytes and their count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg  <= 16'h0000;
            count_reg <= 2'd0;
        end
        else begin
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ src/b64se_queue.sv @@
module b64se_queue
#(
    parameter int DEPTH = b64se_pkg::QueueDepth
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  b64se_pkg::group_t     wr_data,
    input  logic                  rd,
    output b64se_pkg::group_t     rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64se_pkg::group_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Storage of the queued groups.
    always_ff @(posedge clk)
    begin
        if (wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/b64se_back.sv @@
module b64se_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64se_pkg::group_t     q_data,
    input  logic                  q_empty,
    output logic                  q_rd,
    input  logic                  pop,
    output logic                  empty,
    output logic [7:0]            out_char,
    output logic                  last_char
);

    b64se_pkg::group_t cur_reg;
    b64se_pkg::group_t cur_next;
    logic        cur_valid_reg;
    logic        cur_valid_next;
    logic [1:0]  slot_reg;
    logic [1:0]  slot_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_char_reg;
    logic [7:0]  out_char_next;
    logic        last_char_reg;
    logic        last_char_next;
    logic        load_ok;
    logic        emit;
    logic        is_pad;
    logic [5:0]  sextet;

    assign empty     = !out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;

    // The output register takes a new item when it is free or being drained.
    assign load_ok = !out_valid_reg || pop;
    assign emit    = cur_valid_reg && load_ok;
    assign q_rd    = !q_empty && (!cur_valid_reg || (emit && slot_reg == b64se_pkg::LastSlot));

    // Select the six bits of the current slot and decide on padding.
    always_comb
    begin
        case (slot_reg)
            2'd0:    sextet = cur_reg.bytes[23:18];
            2'd1:    sextet = cur_reg.bytes[17:12];
            2'd2:    sextet = cur_reg.bytes[11:6];
            default: sextet = cur_reg.bytes[5:0];
        endcase
        is_pad = ((slot_reg == b64se_pkg::LastSlot) && (cur_reg.pad != b64se_pkg::PadNone))
              || ((slot_reg == 2'd2) && (cur_reg.pad == b64se_pkg::PadTwo));
    end

    // Next state of the character sequencer and the output register.
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_char_next = last_char_reg;
        if (pop && out_valid_reg) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            out_char_next  = is_pad ? b64se_pkg::PadChar : b64se_pkg::sextet_char(sextet);
            last_char_next = cur_reg.last && (slot_reg == b64se_pkg::LastSlot);
            slot_next      = slot_reg + 1'b1;
            if (slot_reg == b64se_pkg::LastSlot) begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_rd) begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            slot_next      = 2'd0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_char_reg  <= out_char_next;
        last_char_reg <= last_char_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            slot_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cur_valid_reg <= cur_valid_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/base64_stream_encoder_unit.sv @@
// Base64 encoder for a byte stream (standard alphabet, '=' padding). One byte
// is pushed per item, with last_byte marking the end of the message; every
// third byte, and the final byte, closes a group of four output characters,
// delivered one per cycle on the result side while it pops them, with last_char
// on the final one. A byte is taken every cycle while the group queue
// (QUEUE_DEPTH entries, two by default) has room, so throughput is set by the
// one-character-per-cycle output register. A closed group passes from the queue
// through the current-group register to the output register.
module base64_stream_encoder_unit
#(
    parameter int QUEUE_DEPTH = b64se_pkg::QueueDepth
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       last_char
);

    b64se_pkg::group_t q_wr_data;
    b64se_pkg::group_t q_rd_data;
    logic q_wr;
    logic q_rd;
    logic q_full;
    logic q_empty;

    // Front part: gathers bytes into groups.
    b64se_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .full      (full),
        .q_wr      (q_wr),
        .q_data    (q_wr_data)
    );

    // Queue of closed groups.
    b64se_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back part: turns each group into four characters.
    b64se_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_rd_data),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .out_char  (out_char),
        .last_char (last_char)
    );

    // The front never writes a group into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_wr && q_full))
        else $error("group written into a full queue");

    // The back never reads from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_rd && q_empty))
        else $error("group read from an empty queue");

    // A padding character that does not end the message is followed by another one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && out_char == b64se_pkg::PadChar && !last_char)
        |=> (!empty && out_char == b64se_pkg::PadChar))
        else $error("padding run broken");

endmodule
